// ----- sv/stc_pkg.sv -----
// Shared types and constants of the scrolling tile cache.
package stc_pkg;

	localparam int COLS = 8;
	localparam int ROWS = 8;
	localparam int BANK_SIZE = COLS * ROWS;
	localparam int COL_W = 3;
	localparam int ROW_W = 3;
	localparam int CELL_W = 6;
	localparam int IDX_W = CELL_W + 1;
	localparam int HANDLE_W = 6;
	localparam int ACC_W = 20;
	localparam int ROW_SPARE_MIN = 2;
	localparam int ROW_BIAS = 2;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [4:0] shift_t;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_SET = 2'd2;
	localparam logic [1:0] REQ_SCROLL = 2'd3;

	localparam logic [1:0] REG_RHOMBUS = 2'd0;
	localparam logic [1:0] REG_VIEW_COLUMNS = 2'd1;
	localparam logic [1:0] REG_VIEW_ROWS = 2'd2;

endpackage

// ----- sv/stc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module stc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/scrolling_tile_cache.sv -----
// Scrolling tile cache: toroidal grid of tile cells with a movable origin.
//
// Input channel (in_valid/in_stall) carries one request per transfer: a lookup,
// an allocating lookup, a set-origin or a scroll. in_stall is high whenever the
// sequencer is busy, so one request is worked on at a time. All address math
// runs through one shared 20-bit adder, one operation per cycle.
// Output channel (out_valid/out_stall) carries result transfers from a single
// output register; last marks the final result of a request.
// Lookup: after offset, column and row math the result comes from S_LK when the location
// is off the grid, else from S_LK2; the next request is taken the cycle after it.
// Set origin: address math (S_DX to S_ROW, S_MV), then a walk over all 64 cells with one
// RAM read (S_RD) and one copy/write (S_WR) per cell, then S_END for the final result.
// A scroll first forms the new origin (S_BC to S_NY) and then redoes the offset math.
// A move of zero skips the walk.
// Clear results are held one deep so that last can be flagged; when the
// receiver stalls the walk holds on the cell that needs the output.
// Reset clears all presence bits, the bank select, the handle counter, the
// origin and the registers (view sizes reset to 8); no clearing pass is needed.
// Registers are written over APB at byte addresses 0, 4 and 8.
module scrolling_tile_cache (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic signed [15:0] x_loc,
	input  logic signed [15:0] y_loc,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        in_cache,
	output logic        present,
	output logic [5:0]  buffer_id,
	output logic        clear_cmd,
	output logic        last
);

	typedef enum logic [4:0] {
		S_IDLE, S_DX, S_DY, S_COL, S_ROW, S_BC, S_BR, S_SUM, S_DIF, S_NX, S_NY,
		S_LK, S_LK2, S_MV, S_RD, S_WR, S_END
	} state_t;

	state_t state_q;

	logic        rh_q;
	logic [3:0]  vc_q;
	logic [3:0]  vr_q;

	logic [1:0]  req_q;
	logic        mv_q;
	logic signed [15:0] x_q, y_q, ox_q, oy_q;
	stc_pkg::acc_t a_q, b_q, c_q, r_q;
	logic        bank_q;
	logic [6:0]  nh_q;
	logic [2*stc_pkg::BANK_SIZE-1:0] pres_q;
	logic        far_q;
	stc_pkg::shift_t cs_q, rs_q;
	logic [stc_pkg::COL_W-1:0] cc_q;
	logic [stc_pkg::ROW_W-1:0] cr_q;
	logic        pend_v_q;
	logic [stc_pkg::HANDLE_W-1:0] pend_q;

	logic        ovalid_q;
	logic        oinc_q, opres_q, oclr_q, olast_q;
	logic [stc_pkg::HANDLE_W-1:0] oid_q;

	// config decode
	logic        cfg_wr;
	logic [3:0]  vc_cl, vr_cl;
	logic [3:0]  ac, ar;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			stc_pkg::REG_RHOMBUS: prdata = {31'b0, rh_q};
			stc_pkg::REG_VIEW_COLUMNS: prdata = {28'b0, vc_q};
			stc_pkg::REG_VIEW_ROWS: prdata = {28'b0, vr_q};
			default: prdata = 32'b0;
		endcase
	end

	always_comb begin
		if (vc_q == 4'd0) begin
			vc_cl = 4'd1;
		end else if (vc_q > 4'(stc_pkg::COLS)) begin
			vc_cl = 4'(stc_pkg::COLS);
		end else begin
			vc_cl = vc_q;
		end
		if (vr_q == 4'd0) begin
			vr_cl = 4'd1;
		end else if (vr_q > 4'(stc_pkg::ROWS)) begin
			vr_cl = 4'(stc_pkg::ROWS);
		end else begin
			vr_cl = vr_q;
		end
		ac = (4'(stc_pkg::COLS) - vc_cl) >> 1;
		ar = ((4'(stc_pkg::ROWS) - vr_cl) > 4'(stc_pkg::ROW_SPARE_MIN)) ?
			4'(stc_pkg::ROW_BIAS) : 4'd0;
	end

	// shared adder
	stc_pkg::acc_t op_a, op_b, sum;
	logic          op_sub;

	always_comb begin
		op_a = '0;
		op_b = '0;
		op_sub = 1'b0;
		case (state_q)
			S_DX: begin
				op_a = stc_pkg::acc_t'(x_q);
				op_b = stc_pkg::acc_t'(ox_q);
				op_sub = 1'b1;
			end
			S_DY: begin
				op_a = stc_pkg::acc_t'(y_q);
				op_b = stc_pkg::acc_t'(oy_q);
				op_sub = 1'b1;
			end
			S_COL: begin
				op_a = a_q;
				op_b = rh_q ? b_q : '0;
				op_sub = rh_q;
			end
			S_ROW: begin
				op_a = rh_q ? a_q : b_q;
				op_b = rh_q ? b_q : '0;
			end
			S_BC: begin
				op_a = c_q;
				op_b = stc_pkg::acc_t'(ac);
				op_sub = 1'b1;
			end
			S_BR: begin
				op_a = r_q;
				op_b = stc_pkg::acc_t'(ar);
				op_sub = 1'b1;
			end
			S_SUM: begin
				op_a = c_q;
				op_b = rh_q ? r_q : '0;
			end
			S_DIF: begin
				op_a = r_q;
				op_b = rh_q ? c_q : '0;
				op_sub = rh_q;
			end
			S_NX: begin
				op_a = rh_q ? (a_q >>> 1) : a_q;
				op_b = stc_pkg::acc_t'(ox_q);
			end
			S_NY: begin
				op_a = rh_q ? (b_q >>> 1) : b_q;
				op_b = stc_pkg::acc_t'(oy_q);
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign sum = op_a + (op_b ^ {stc_pkg::ACC_W{op_sub}}) + stc_pkg::acc_t'(op_sub);

	// cell indexing
	logic                       lk_in;
	logic [stc_pkg::IDX_W-1:0]  lk_idx, src_idx, dst_idx;
	stc_pkg::shift_t            dc, dr;
	logic [stc_pkg::COL_W-1:0]  dcol;
	logic [stc_pkg::ROW_W-1:0]  drow;
	logic                       wr_col, wr_row;
	logic                       mv_zero, mv_far;

	assign lk_in = !c_q[stc_pkg::ACC_W-1] && (c_q < stc_pkg::acc_t'(stc_pkg::COLS)) &&
		!r_q[stc_pkg::ACC_W-1] && (r_q < stc_pkg::acc_t'(stc_pkg::ROWS));
	assign lk_idx = {bank_q, stc_pkg::CELL_W'(r_q[stc_pkg::ROW_W-1:0]) *
		stc_pkg::CELL_W'(stc_pkg::COLS) + stc_pkg::CELL_W'(c_q[stc_pkg::COL_W-1:0])};
	assign src_idx = {bank_q, stc_pkg::CELL_W'(cr_q) * stc_pkg::CELL_W'(stc_pkg::COLS) +
		stc_pkg::CELL_W'(cc_q)};
	assign mv_zero = (c_q == '0) && (r_q == '0);
	assign mv_far = (c_q >= stc_pkg::acc_t'(stc_pkg::COLS)) ||
		(c_q <= stc_pkg::acc_t'(-stc_pkg::COLS)) ||
		(r_q >= stc_pkg::acc_t'(stc_pkg::ROWS)) ||
		(r_q <= stc_pkg::acc_t'(-stc_pkg::ROWS));

	always_comb begin
		dc = stc_pkg::shift_t'({2'b00, cc_q}) + cs_q;
		dr = stc_pkg::shift_t'({2'b00, cr_q}) + rs_q;
		wr_col = 1'b0;
		wr_row = 1'b0;
		if (dc < stc_pkg::shift_t'(0)) begin
			dc = dc + stc_pkg::shift_t'(stc_pkg::COLS);
			wr_col = 1'b1;
		end else if (dc >= stc_pkg::shift_t'(stc_pkg::COLS)) begin
			dc = dc - stc_pkg::shift_t'(stc_pkg::COLS);
			wr_col = 1'b1;
		end
		if (dr < stc_pkg::shift_t'(0)) begin
			dr = dr + stc_pkg::shift_t'(stc_pkg::ROWS);
			wr_row = 1'b1;
		end else if (dr >= stc_pkg::shift_t'(stc_pkg::ROWS)) begin
			dr = dr - stc_pkg::shift_t'(stc_pkg::ROWS);
			wr_row = 1'b1;
		end
		dcol = dc[stc_pkg::COL_W-1:0];
		drow = dr[stc_pkg::ROW_W-1:0];
	end

	assign dst_idx = {~bank_q, stc_pkg::CELL_W'(drow) * stc_pkg::CELL_W'(stc_pkg::COLS) +
		stc_pkg::CELL_W'(dcol)};

	// handle RAM
	logic                          ram_we;
	logic [stc_pkg::IDX_W-1:0]     ram_waddr, ram_raddr;
	logic [stc_pkg::HANDLE_W-1:0]  ram_wdata, ram_rdata;

	stc_ram #(
		.WIDTH(stc_pkg::HANDLE_W),
		.DEPTH(2 * stc_pkg::BANK_SIZE)
	) u_handle_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// per-state control
	logic out_free;
	logic lk_p, can_alloc, alloc_go;
	logic src_p, clr, wr_go, last_cell;
	logic out_load;
	logic ld_inc, ld_pres, ld_clr, ld_last;
	logic [stc_pkg::HANDLE_W-1:0] ld_id;

	assign out_free = !ovalid_q || !out_stall;
	assign lk_p = pres_q[lk_idx];
	assign can_alloc = (req_q == stc_pkg::REQ_ALLOC) && !lk_p && !nh_q[6];
	assign alloc_go = (state_q == S_LK2) && can_alloc && out_free;
	assign src_p = pres_q[src_idx];
	assign clr = src_p && (far_q || wr_col || wr_row);
	assign wr_go = !(clr && pend_v_q && !out_free);
	assign last_cell = (cr_q == stc_pkg::ROW_W'(stc_pkg::ROWS - 1)) &&
		(cc_q == stc_pkg::COL_W'(stc_pkg::COLS - 1));

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = lk_idx;
		ram_wdata = nh_q[stc_pkg::HANDLE_W-1:0];
		ram_raddr = (state_q == S_RD || state_q == S_WR) ? src_idx : lk_idx;
		if (alloc_go) begin
			ram_we = 1'b1;
		end else if (state_q == S_WR && !far_q && wr_go) begin
			ram_we = 1'b1;
			ram_waddr = dst_idx;
			ram_wdata = ram_rdata;
		end
	end

	always_comb begin
		out_load = 1'b0;
		ld_inc = 1'b0;
		ld_pres = 1'b0;
		ld_id = '0;
		ld_clr = 1'b0;
		ld_last = 1'b1;
		case (state_q)
			S_LK: begin
				out_load = !lk_in && out_free;
			end
			S_LK2: begin
				out_load = out_free;
				ld_inc = 1'b1;
				ld_pres = lk_p || can_alloc;
				ld_id = can_alloc ? nh_q[stc_pkg::HANDLE_W-1:0] : (lk_p ? ram_rdata : '0);
			end
			S_MV: begin
				out_load = mv_zero && out_free;
			end
			S_WR: begin
				out_load = clr && pend_v_q && out_free;
				ld_pres = 1'b1;
				ld_id = pend_q;
				ld_clr = 1'b1;
				ld_last = 1'b0;
			end
			S_END: begin
				out_load = out_free;
				ld_pres = pend_v_q;
				ld_id = pend_v_q ? pend_q : '0;
				ld_clr = pend_v_q;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rh_q <= 1'b0;
			vc_q <= 4'd8;
			vr_q <= 4'd8;
			mv_q <= 1'b0;
			ox_q <= '0;
			oy_q <= '0;
			bank_q <= 1'b0;
			nh_q <= '0;
			pres_q <= '0;
			pend_v_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					stc_pkg::REG_RHOMBUS: rh_q <= pwdata[0];
					stc_pkg::REG_VIEW_COLUMNS: vc_q <= pwdata[3:0];
					stc_pkg::REG_VIEW_ROWS: vr_q <= pwdata[3:0];
					default: ;
				endcase
			end

			if (out_load) begin
				ovalid_q <= 1'b1;
				oinc_q <= ld_inc;
				opres_q <= ld_pres;
				oid_q <= ld_id;
				oclr_q <= ld_clr;
				olast_q <= ld_last;
			end else if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= req_type;
						x_q <= x_loc;
						y_q <= y_loc;
						mv_q <= 1'b0;
						state_q <= S_DX;
					end
				end
				S_DX: begin
					a_q <= sum;
					state_q <= S_DY;
				end
				S_DY: begin
					b_q <= sum;
					state_q <= S_COL;
				end
				S_COL: begin
					c_q <= sum;
					state_q <= S_ROW;
				end
				S_ROW: begin
					r_q <= sum;
					if (mv_q || req_q == stc_pkg::REQ_SET) begin
						state_q <= S_MV;
					end else if (req_q == stc_pkg::REQ_SCROLL) begin
						state_q <= S_BC;
					end else begin
						state_q <= S_LK;
					end
				end
				S_BC: begin
					c_q <= sum;
					state_q <= S_BR;
				end
				S_BR: begin
					r_q <= sum;
					state_q <= S_SUM;
				end
				S_SUM: begin
					a_q <= sum;
					state_q <= S_DIF;
				end
				S_DIF: begin
					b_q <= sum;
					state_q <= S_NX;
				end
				S_NX: begin
					x_q <= sum[15:0];
					state_q <= S_NY;
				end
				S_NY: begin
					y_q <= sum[15:0];
					mv_q <= 1'b1;
					state_q <= S_DX;
				end
				S_LK: begin
					if (lk_in) begin
						state_q <= S_LK2;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_LK2: begin
					if (out_free) begin
						if (can_alloc) begin
							pres_q[lk_idx] <= 1'b1;
							nh_q <= nh_q + 7'd1;
						end
						state_q <= S_IDLE;
					end
				end
				S_MV: begin
					ox_q <= x_q;
					oy_q <= y_q;
					far_q <= mv_far;
					cs_q <= stc_pkg::shift_t'(-c_q);
					rs_q <= stc_pkg::shift_t'(-r_q);
					cc_q <= '0;
					cr_q <= '0;
					pend_v_q <= 1'b0;
					if (mv_zero) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (wr_go) begin
						if (!far_q) begin
							pres_q[dst_idx] <= src_p;
						end
						if (clr) begin
							pend_q <= ram_rdata;
							pend_v_q <= 1'b1;
						end
						if (last_cell) begin
							state_q <= S_END;
						end else begin
							state_q <= S_RD;
							if (cc_q == stc_pkg::COL_W'(stc_pkg::COLS - 1)) begin
								cc_q <= '0;
								cr_q <= cr_q + 1'b1;
							end else begin
								cc_q <= cc_q + 1'b1;
							end
						end
					end
				end
				S_END: begin
					if (out_free) begin
						if (!far_q) begin
							bank_q <= ~bank_q;
						end
						pend_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign in_cache = oinc_q;
	assign present = opres_q;
	assign buffer_id = oid_q;
	assign clear_cmd = oclr_q;
	assign last = olast_q;

endmodule
